### hdl/mh2ab_pkg.sv
`timescale 1ns / 1ps

package mh2ab_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned HASH_W    = 32;
    localparam int unsigned PEND_W    = 24;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 2;
    // 100 * hash and pct * (2^32 - 1) both fit in 39 bits
    localparam int unsigned CMP_W     = HASH_W + PCT_W;

    localparam logic [HASH_W-1:0]  MIX_MUL        = 32'h5bd1e995;
    localparam logic [HASH_W-1:0]  MAX_KEY_LENGTH = 32'd65535;
    localparam logic [PCT_W-1:0]   PCT_MAX        = 7'd100;
    localparam logic [PHASE_W-1:0] PHASE_FULL     = 2'd3;
    localparam logic [PHASE_W-1:0] PHASE_EMPTY    = 2'd0;

    localparam int unsigned MIX_SHIFT  = 24;
    localparam int unsigned FIN_SHIFT1 = 13;
    localparam int unsigned FIN_SHIFT2 = 15;

    localparam logic M_BUCKET_A = 1'b0;
    localparam logic M_BUCKET_B = 1'b1;

endpackage

### hdl/mh2ab_mul.sv
`timescale 1ns / 1ps

// shared multiply by the mix constant, registered output, low 32 bits kept
module mh2ab_mul (
    input  logic                              aclk,
    input  logic [mh2ab_pkg::HASH_W-1:0]      op_a,
    output logic [mh2ab_pkg::HASH_W-1:0]      prod
);

    logic [mh2ab_pkg::HASH_W-1:0] prod_reg;
    logic [mh2ab_pkg::HASH_W-1:0] prod_next;

    assign prod_next = op_a * mh2ab_pkg::MIX_MUL;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

### hdl/murmur2_hash_ab_split.sv
`timescale 1ns / 1ps

// MurmurHash2 (32 bit, seed = key length) over a byte stream, with A/B split.
// Input words on s_*: one key byte each; tlast ends the key, tuser marks a
// zero-length key (its hash is sent with no further bytes, any key in progress is dropped).
// message_length is taken from the first byte of a key only.
// Output words on m_*: one per key, hash in tdata, tuser = {split_valid, bucket}.
// Bucket 0 (A) when hash > floor(pct * (2^32-1) / 100), else 1 (B); both
// tuser bits are 0 while split_percent is 0. cfg_wen writes split_percent,
// values above 100 are stored as 100; write only while idle.
// s_tready is high only in the idle state. A byte that does not close a
// 4-byte word returns to idle; one that closes it passes MK1, MK2, MH, MHX:
// three multiplies, two dependent, in turn on the single shared multiplier. A
// last byte adds finalization: TAIL, TMW (nonempty tail: one more multiply),
// FMUL, FWAIT, SPLIT, then OUT loads the output register. Empty key: SPLIT, OUT.
// The output register holds a word until taken; the block finishes the next
// key meanwhile and stalls only when that key's hash is ready to load.
// Reset (aresetn low, synchronous) clears key state, the output valid and
// split_percent.
module murmur2_hash_ab_split (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [mh2ab_pkg::PCT_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mh2ab_pkg::S_TDATA_W-1:0]     s_tdata,  // data_byte, message_length
    input  logic                                s_tlast,
    input  logic                                s_tuser,  // empty_message
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mh2ab_pkg::HASH_W-1:0]        m_tdata,  // hash_value
    output logic [mh2ab_pkg::M_TUSER_W-1:0]     m_tuser   // bucket, split_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MK1,
        ST_MK2,
        ST_MH,
        ST_MHX,
        ST_TAIL,
        ST_TMW,
        ST_FMUL,
        ST_FWAIT,
        ST_SPLIT,
        ST_OUT
    } state_t;

    state_t                             state_reg, state_next;
    logic [mh2ab_pkg::HASH_W-1:0]       h_reg, h_next;
    logic [mh2ab_pkg::HASH_W-1:0]       k_reg, k_next;
    logic [mh2ab_pkg::PEND_W-1:0]       pend_reg, pend_next;
    logic [mh2ab_pkg::PHASE_W-1:0]      phase_reg, phase_next;
    logic                               inmsg_reg, inmsg_next;
    logic                               last_reg, last_next;
    logic [mh2ab_pkg::PCT_W-1:0]        pct_reg, pct_next;
    logic [mh2ab_pkg::CMP_W-1:0]        c100_reg, c100_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [mh2ab_pkg::HASH_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [mh2ab_pkg::M_TUSER_W-1:0]    m_tuser_reg, m_tuser_next;

    logic [mh2ab_pkg::HASH_W-1:0]       mul_a;
    logic [mh2ab_pkg::HASH_W-1:0]       prod;

    logic [mh2ab_pkg::BYTE_W-1:0]       s_byte;
    logic [mh2ab_pkg::LEN_W-1:0]        s_len;
    logic [mh2ab_pkg::HASH_W-1:0]       seed;
    logic [mh2ab_pkg::HASH_W-1:0]       h_cur;
    logic [mh2ab_pkg::PEND_W-1:0]       pend_cur;
    logic [mh2ab_pkg::PHASE_W-1:0]      phase_cur;
    logic [mh2ab_pkg::CMP_W-1:0]        thr_scaled;
    logic                               split_on;
    logic                               out_free;

    mh2ab_mul u_mul (
        .aclk  (aclk),
        .op_a  (mul_a),
        .prod  (prod)
    );

    assign s_byte    = s_tdata[mh2ab_pkg::BYTE_W-1:0];
    assign s_len     = s_tdata[mh2ab_pkg::BYTE_W +: mh2ab_pkg::LEN_W];
    assign seed      = (mh2ab_pkg::HASH_W'(s_len) > mh2ab_pkg::MAX_KEY_LENGTH)
                       ? mh2ab_pkg::MAX_KEY_LENGTH : mh2ab_pkg::HASH_W'(s_len);
    assign h_cur     = inmsg_reg ? h_reg : seed;
    assign pend_cur  = inmsg_reg ? pend_reg : '0;
    assign phase_cur = inmsg_reg ? phase_reg : mh2ab_pkg::PHASE_EMPTY;

    // pct * (2^32 - 1)
    assign thr_scaled = {pct_reg, {mh2ab_pkg::HASH_W{1'b0}}}
                        - mh2ab_pkg::CMP_W'(pct_reg);
    assign split_on   = (pct_reg != '0);
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb begin
        case (state_reg)
            ST_MK1:  mul_a = k_reg;
            ST_MK2:  mul_a = prod ^ (prod >> mh2ab_pkg::MIX_SHIFT);
            ST_MH:   mul_a = h_reg;
            ST_TAIL: mul_a = h_reg ^ mh2ab_pkg::HASH_W'(pend_reg);
            ST_FMUL: mul_a = h_reg;
            default: mul_a = h_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        h_next        = h_reg;
        k_next        = k_reg;
        pend_next     = pend_reg;
        phase_next    = phase_reg;
        inmsg_next    = inmsg_reg;
        last_next     = last_reg;
        pct_next      = pct_reg;
        c100_next     = c100_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cfg_wen) begin
            pct_next = (cfg_wdata > mh2ab_pkg::PCT_MAX) ? mh2ab_pkg::PCT_MAX : cfg_wdata;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        // zero-length key hashes to 0
                        h_next     = '0;
                        pend_next  = '0;
                        phase_next = mh2ab_pkg::PHASE_EMPTY;
                        inmsg_next = 1'b0;
                        state_next = ST_SPLIT;
                    end else begin
                        h_next     = h_cur;
                        inmsg_next = 1'b1;
                        last_next  = s_tlast;
                        if (phase_cur == mh2ab_pkg::PHASE_FULL) begin
                            k_next     = {s_byte, pend_cur};
                            pend_next  = '0;
                            phase_next = mh2ab_pkg::PHASE_EMPTY;
                            state_next = ST_MK1;
                        end else begin
                            pend_next  = pend_cur
                                         | (mh2ab_pkg::PEND_W'(s_byte) << {phase_cur, 3'b000});
                            phase_next = phase_cur + 1'b1;
                            state_next = s_tlast ? ST_TAIL : ST_IDLE;
                        end
                    end
                end
            end
            ST_MK1: begin
                state_next = ST_MK2;
            end
            ST_MK2: begin
                state_next = ST_MH;
            end
            ST_MH: begin
                k_next     = prod;
                state_next = ST_MHX;
            end
            ST_MHX: begin
                h_next     = prod ^ k_reg;
                state_next = last_reg ? ST_TAIL : ST_IDLE;
            end
            ST_TAIL: begin
                if (phase_reg != mh2ab_pkg::PHASE_EMPTY) begin
                    state_next = ST_TMW;
                end else begin
                    h_next     = h_reg ^ (h_reg >> mh2ab_pkg::FIN_SHIFT1);
                    state_next = ST_FMUL;
                end
            end
            ST_TMW: begin
                h_next     = prod ^ (prod >> mh2ab_pkg::FIN_SHIFT1);
                state_next = ST_FMUL;
            end
            ST_FMUL: begin
                state_next = ST_FWAIT;
            end
            ST_FWAIT: begin
                h_next     = prod ^ (prod >> mh2ab_pkg::FIN_SHIFT2);
                pend_next  = '0;
                phase_next = mh2ab_pkg::PHASE_EMPTY;
                inmsg_next = 1'b0;
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                // 100 * hash
                c100_next  = (mh2ab_pkg::CMP_W'(h_reg) << 6)
                             + (mh2ab_pkg::CMP_W'(h_reg) << 5)
                             + (mh2ab_pkg::CMP_W'(h_reg) << 2);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = h_reg;
                    m_tuser_next  = {split_on,
                                     (split_on && !(c100_reg > thr_scaled))
                                     ? mh2ab_pkg::M_BUCKET_B : mh2ab_pkg::M_BUCKET_A};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            h_reg        <= '0;
            pend_reg     <= '0;
            phase_reg    <= mh2ab_pkg::PHASE_EMPTY;
            inmsg_reg    <= 1'b0;
            last_reg     <= 1'b0;
            pct_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            h_reg        <= h_next;
            pend_reg     <= pend_next;
            phase_reg    <= phase_next;
            inmsg_reg    <= inmsg_next;
            last_reg     <= last_next;
            pct_reg      <= pct_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        k_reg       <= k_next;
        c100_reg    <= c100_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pct_reg <= mh2ab_pkg::PCT_MAX)
        else $error("split percent above limit");

    a_bucket_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> !m_tuser[0])
        else $error("bucket set with split disabled");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !inmsg_reg |-> (phase_reg == mh2ab_pkg::PHASE_EMPTY) && (pend_reg == '0))
        else $error("partial word held outside a key");

    a_empty_path: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> (state_reg == ST_SPLIT) && (h_reg == '0))
        else $error("empty key not sent to split stage");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && !out_free |=> (state_reg == ST_OUT) && $stable(h_reg))
        else $error("result lost while output stalled");

endmodule

### tb/tb_murmur2_hash_ab_split.sv
`timescale 1ns / 1ps

module tb_murmur2_hash_ab_split;
    import mh2ab_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_WORDS  = 60;
    localparam int unsigned NUM_PHASES   = 6;

    typedef struct packed {
        logic [LEN_W-1:0]  msg_len;
        logic [BYTE_W-1:0] key_byte;
        logic              is_last;
        logic              is_empty;
    } key_word_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic              bucket;
        logic              split_valid;
    } hash_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [PCT_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // data_byte, message_length
    logic                 s_tlast   = 1'b0;
    logic                 s_tuser   = 1'b0; // empty_message
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [HASH_W-1:0]    m_tdata;          // hash_value
    logic [M_TUSER_W-1:0] m_tuser;          // bucket, split_valid

    // predictor state
    logic [HASH_W-1:0]  key_hash  = '0;
    logic [PEND_W-1:0]  key_pend  = '0;
    logic [PHASE_W-1:0] key_fill  = PHASE_EMPTY;
    logic               key_open  = 1'b0;
    logic [PCT_W-1:0]   split_pct = '0;

    hash_result_t hash_expected[$];
    hash_result_t hash_due;
    key_word_t    key_words[$];
    key_word_t    tx_word;

    logic        s_taken      = 1'b0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned queued_words = 0;
    int unsigned cycles       = 0;
    int unsigned errors       = 0;

    murmur2_hash_ab_split dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [HASH_W-1:0] avalanche(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] x;
        x = h ^ (h >> FIN_SHIFT1);
        x = x * MIX_MUL;
        return x ^ (x >> FIN_SHIFT2);
    endfunction

    function automatic hash_result_t bucketize(input logic [HASH_W-1:0] h);
        hash_result_t r;
        logic [63:0]  thr;
        r.hash        = h;
        r.bucket      = 1'b0;
        r.split_valid = 1'b0;
        if (split_pct != 0) begin
            thr           = (64'(split_pct) * 64'hffff_ffff) / 64'd100;
            r.bucket      = (64'(h) > thr) ? M_BUCKET_A : M_BUCKET_B;
            r.split_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic drop_key();
        key_hash = '0;
        key_pend = '0;
        key_fill = PHASE_EMPTY;
        key_open = 1'b0;
    endtask

    task automatic hash_word(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len,
                             input logic is_last, input logic is_empty);
        logic [HASH_W-1:0] k;
        logic [HASH_W-1:0] h;
        if (is_empty) begin
            drop_key();
            hash_expected.push_back(bucketize(avalanche('0)));
        end else begin
            if (!key_open) begin
                key_hash = (HASH_W'(len) > MAX_KEY_LENGTH) ? MAX_KEY_LENGTH : HASH_W'(len);
                key_pend = '0;
                key_fill = PHASE_EMPTY;
                key_open = 1'b1;
            end
            if (key_fill == PHASE_FULL) begin
                k        = {b, key_pend};
                k        = k * MIX_MUL;
                k        = k ^ (k >> MIX_SHIFT);
                k        = k * MIX_MUL;
                key_hash = (key_hash * MIX_MUL) ^ k;
                key_pend = '0;
                key_fill = PHASE_EMPTY;
            end else begin
                key_pend = key_pend | (PEND_W'(b) << (BYTE_W * key_fill));
                key_fill = key_fill + 1'b1;
            end
            if (is_last) begin
                h = key_hash;
                if (key_fill != PHASE_EMPTY)
                    h = (h ^ HASH_W'(key_pend)) * MIX_MUL;
                drop_key();
                hash_expected.push_back(bucketize(avalanche(h)));
            end
        end
    endtask

    // monitor and checker
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (cfg_wen)
                split_pct = (cfg_wdata > PCT_MAX) ? PCT_MAX : cfg_wdata;
            if (m_tvalid && m_tready) begin
                if (hash_expected.size() == 0) begin
                    $display("%0t: unexpected word, expected none got hash=%h tuser=%b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    hash_due = hash_expected.pop_front();
                    if (m_tdata !== hash_due.hash) begin
                        $display("%0t: hash expected %h got %h", $time, hash_due.hash, m_tdata);
                        errors++;
                    end
                    if (m_tuser[0] !== hash_due.bucket) begin
                        $display("%0t: bucket expected %b got %b", $time,
                                 hash_due.bucket, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== hash_due.split_valid) begin
                        $display("%0t: split_valid expected %b got %b", $time,
                                 hash_due.split_valid, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                hash_word(s_tdata[BYTE_W-1:0], s_tdata[BYTE_W +: LEN_W], s_tlast, s_tuser);
        end
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || s_taken)) begin
            if (key_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                tx_word  = key_words.pop_front();
                s_tdata  <= {tx_word.msg_len, tx_word.key_byte};
                s_tlast  <= tx_word.is_last;
                s_tuser  <= tx_word.is_empty;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_murmur2_hash_ab_split failed");
            $finish;
        end
    end

    task automatic push_word(input key_word_t w);
        key_words.push_back(w);
        queued_words++;
    endtask

    task automatic queue_key(input int unsigned n, input bit closed, input bit true_len);
        key_word_t w;
        for (int unsigned i = 0; i < n; i++) begin
            w.key_byte = BYTE_W'($urandom);
            w.msg_len  = (i == 0 && true_len) ? LEN_W'(n) : LEN_W'($urandom);
            w.is_last  = closed && (i == n - 1);
            w.is_empty = 1'b0;
            push_word(w);
        end
    endtask

    task automatic queue_fixed_key(input int unsigned n, input logic [BYTE_W-1:0] b);
        key_word_t w;
        for (int unsigned i = 0; i < n; i++) begin
            w.key_byte = b + BYTE_W'(i);
            w.msg_len  = (i == 0) ? LEN_W'(n) : 16'hffff;
            w.is_last  = (i == n - 1);
            w.is_empty = 1'b0;
            push_word(w);
        end
    endtask

    task automatic queue_empty();
        key_word_t w;
        w.key_byte = BYTE_W'($urandom);
        w.msg_len  = LEN_W'($urandom);
        w.is_last  = 1'($urandom_range(0, 1));
        w.is_empty = 1'b1;
        push_word(w);
    endtask

    task automatic queue_directed();
        push_word('{16'h0000, 8'h00, 1'b0, 1'b1});   // empty key
        push_word('{16'hffff, 8'hff, 1'b1, 1'b1});   // empty wins over last
        push_word('{16'h0001, 8'h00, 1'b1, 1'b0});   // one-byte key
        push_word('{16'hffff, 8'hff, 1'b1, 1'b0});   // max length, mismatch
        push_word('{16'h0000, 8'h5a, 1'b0, 1'b0});   // declared zero
        push_word('{16'hffff, 8'ha5, 1'b1, 1'b0});   // later length ignored
        queue_fixed_key(3, 8'hfd);
        queue_fixed_key(4, 8'h01);                    // full word, no tail
        queue_fixed_key(5, 8'hfc);                    // word plus one-byte tail
        push_word('{16'h0002, 8'h11, 1'b0, 1'b0});   // key dropped by empty
        push_word('{16'h1234, 8'h22, 1'b0, 1'b0});
        push_word('{16'h0000, 8'h00, 1'b0, 1'b1});
    endtask

    task automatic queue_random(input int unsigned n);
        int unsigned start;
        int unsigned pick;
        int unsigned klen;
        start = queued_words;
        while (queued_words - start < n) begin
            pick = $urandom_range(0, 99);
            klen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            if (pick < 80) begin
                queue_key(klen, 1'b1, pick < 68);
            end else if (pick < 88) begin
                queue_key($urandom_range(1, 6), 1'b0, 1'b1);
            end else if (pick < 95) begin
                queue_empty();
            end else begin
                queue_key($urandom_range(1, 6), 1'b0, 1'b1);
                queue_empty();
            end
        end
        queue_key($urandom_range(1, 8), 1'b1, 1'b1);
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (key_words.size() != 0 || s_tvalid);
        do @(negedge aclk); while (hash_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [PCT_W-1:0] phase_pct(input int unsigned p);
        case (p)
            0: return 7'd0;
            1: return PCT_MAX;
            2: return 7'd127;   // saturates
            3: return 7'd1;
            4: return 7'd99;
            default: return PCT_W'($urandom_range(2, 98));
        endcase
    endfunction

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            @(negedge aclk);
            cfg_wen   <= 1'b1;
            cfg_wdata <= phase_pct(p);
            @(negedge aclk);
            cfg_wen   <= 1'b0;
            @(posedge aclk);
            if (p < 2) begin
                tx_idle_pct = 29;
                rx_idle_pct = 64;
            end else if (p < 4) begin
                tx_idle_pct = 64;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 0)
                queue_directed();
            queue_random(PHASE_WORDS);
            if (p == NUM_PHASES - 1)
                hold_req++;
            wait_idle();
        end
        if (errors == 0)
            $display("tb_murmur2_hash_ab_split passed");
        else
            $display("tb_murmur2_hash_ab_split failed");
        $finish;
    end

endmodule
